[hdl/fpes_pkg.sv]
`timescale 1ns / 1ps

package fpes_pkg;

    localparam int MAX_PIECES = 1024;
    localparam int MAX_BATCH  = 32;
    localparam int PIECE_W    = $clog2(MAX_PIECES);
    localparam int CNT_W      = PIECE_W + 1;
    localparam int ROW_BITS   = 32;
    localparam int SEL_W      = $clog2(ROW_BITS);
    localparam int ROWS       = MAX_PIECES / ROW_BITS;
    localparam int ROW_AW     = $clog2(ROWS);

    localparam int TOTAL_W    = 11;
    localparam int BATCH_W    = 6;
    localparam int IDX_W      = 16;
    localparam int PEER_W     = 16;
    localparam int SCORE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_PIECE_TOTAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_BODY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE       = 3'd4;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;
    localparam logic [BATCH_W-1:0] BATCH_RESET = 6'd1;
    localparam logic [SCORE_W-1:0] SCORE_RESET = 8'd1;

    typedef enum logic [1:0] {
        MODE_PUBLISH,
        MODE_BODY_READY,
        MODE_TICK,
        MODE_PIECE
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DELIVER,
        KIND_SEND,
        KIND_ARM,
        KIND_FEEDBACK
    } kind_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] piece_total;
        logic [BATCH_W-1:0] batch_size;
        logic               relay;
        logic [SCORE_W-1:0] score;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic value;
    } body_load_t;

    typedef struct packed {
        kind_t              kind;
        logic [PIECE_W-1:0] piece;
        logic               excl;
        logic [PEER_W-1:0]  peer;
        logic [SCORE_W-1:0] fb;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    last;
        result_t res;
    } push_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [PIECE_W-1:0] addr;
    } map_req_t;

endpackage

[hdl/fpes_cfg.sv]
`timescale 1ns / 1ps

module fpes_cfg
    import fpes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output body_load_t            body_load
);

    logic [TOTAL_W-1:0] piece_total_reg;
    logic [BATCH_W-1:0] batch_size_reg;
    logic               relay_reg;
    logic [SCORE_W-1:0] score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_total_reg <= TOTAL_RESET;
            batch_size_reg  <= BATCH_RESET;
            relay_reg       <= 1'b0;
            score_reg       <= SCORE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PIECE_TOTAL: piece_total_reg <= cfg_data[TOTAL_W-1:0];
                REG_BATCH_SIZE:  batch_size_reg  <= cfg_data[BATCH_W-1:0];
                REG_RELAY:       relay_reg       <= cfg_data[0];
                REG_SCORE:       score_reg       <= cfg_data[SCORE_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.piece_total = piece_total_reg;
    assign cfg.batch_size  = batch_size_reg;
    assign cfg.relay       = relay_reg;
    assign cfg.score       = score_reg;

    // start flag write loads the body-present flag
    assign body_load.load  = cfg_valid && (cfg_index == REG_START_BODY);
    assign body_load.value = cfg_data[0];

endmodule

[hdl/fpes_map_ram.sv]
`timescale 1ns / 1ps

module fpes_map_ram
    import fpes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  map_req_t req,
    output logic     emitted
);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]     row_vld_reg;
    logic [ROW_BITS-1:0] rd_row_reg;
    logic                rd_vld_reg;
    logic [SEL_W-1:0]    rd_sel_reg;
    logic [ROW_AW-1:0]   row;
    logic [SEL_W-1:0]    sel;
    logic [ROW_BITS-1:0] wr_row;

    assign row = req.addr[PIECE_W-1:SEL_W];
    assign sel = req.addr[SEL_W-1:0];

    // write always follows a read of the same row
    assign wr_row = (rd_vld_reg ? rd_row_reg : '0) | (ROW_BITS'(1) << sel);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[row] <= wr_row;
        end
        if (req.rd_en)
        begin
            rd_row_reg <= mem[row];
            rd_sel_reg <= sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_vld_reg[row] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= row_vld_reg[row];
            end
        end
    end

    assign emitted = rd_vld_reg & rd_row_reg[rd_sel_reg];

endmodule

[hdl/fpes_ctrl.sv]
`timescale 1ns / 1ps

module fpes_ctrl
    import fpes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  body_load_t        body_load,
    input  logic              in_valid,
    output logic              in_ready,
    input  mode_t             mode,
    input  logic [IDX_W-1:0]  piece_index,
    input  logic              is_duplicate,
    input  logic [PEER_W-1:0] sender_peer,
    output map_req_t          map_req,
    input  logic              emitted,
    input  logic              out_space,
    output push_t             push
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELIV,
        ST_B_START,
        ST_B_TEST,
        ST_B_CHK,
        ST_A_FB,
        ST_A_CHK,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               dup_reg, dup_next;
    logic [PEER_W-1:0]  sender_reg, sender_next;
    logic               body_reg, body_next;
    logic               pub_reg, pub_next;
    logic               batch_go_reg, batch_go_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [BATCH_W-1:0] left_reg, left_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            pend_reg, pend_next;

    logic               emit;
    result_t            new_res;
    logic               can_emit;
    logic               fin_push;
    logic [CNT_W-1:0]   total_eff;
    logic [BATCH_W-1:0] batch_eff;
    logic               scan_more;

    assign total_eff = (cfg.piece_total > TOTAL_W'(MAX_PIECES)) ? CNT_W'(MAX_PIECES)
                                                                  : CNT_W'(cfg.piece_total);
    assign batch_eff = (cfg.batch_size == '0) ? BATCH_W'(1)
                     : (cfg.batch_size > BATCH_W'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH)
                     : cfg.batch_size;
    assign scan_more = scan_reg < total_eff;
    assign can_emit  = !pend_valid_reg || out_space;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        dup_next        = dup_reg;
        sender_next     = sender_reg;
        body_next       = body_reg;
        pub_next        = pub_reg;
        batch_go_next   = batch_go_reg;
        scan_next       = scan_reg;
        left_next       = left_reg;
        emit            = 1'b0;
        new_res         = '0;
        fin_push        = 1'b0;
        map_req.rd_en   = 1'b0;
        map_req.wr_en   = 1'b0;
        map_req.addr    = scan_reg[PIECE_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next    = piece_index;
                    dup_next    = is_duplicate;
                    sender_next = sender_peer;
                    unique case (mode)
                        MODE_PUBLISH:
                        begin
                            if (!body_reg)
                            begin
                                pub_next      = 1'b1;
                                body_next     = 1'b1;
                                batch_go_next = 1'b1;
                                state_next    = ST_DELIV;
                            end
                        end
                        MODE_BODY_READY:
                        begin
                            if (!body_reg)
                            begin
                                body_next     = 1'b1;
                                batch_go_next = cfg.relay;
                                state_next    = ST_DELIV;
                            end
                        end
                        MODE_TICK:  state_next = ST_B_START;
                        MODE_PIECE: state_next = ST_A_FB;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DELIV:
            begin
                emit         = 1'b1;
                new_res.kind = KIND_DELIVER;
                if (can_emit)
                begin
                    state_next = batch_go_reg ? ST_B_START : ST_FIN;
                end
            end
            ST_B_START:
            begin
                if (body_reg && (pub_reg || cfg.relay))
                begin
                    left_next  = batch_eff;
                    state_next = ST_B_TEST;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_B_TEST:
            begin
                if (scan_more && (left_reg != '0))
                begin
                    map_req.rd_en = 1'b1;
                    state_next    = ST_B_CHK;
                end
                else if (scan_more)
                begin
                    emit         = 1'b1;
                    new_res.kind = KIND_ARM;
                    if (can_emit)
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_B_CHK:
            begin
                if (emitted)
                begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = ST_B_TEST;
                end
                else
                begin
                    emit          = 1'b1;
                    new_res.kind  = KIND_SEND;
                    new_res.piece = scan_reg[PIECE_W-1:0];
                    if (can_emit)
                    begin
                        map_req.wr_en = 1'b1;
                        scan_next     = scan_reg + CNT_W'(1);
                        left_next     = left_reg - BATCH_W'(1);
                        state_next    = ST_B_TEST;
                    end
                end
            end
            ST_A_FB:
            begin
                emit         = 1'b1;
                new_res.kind = KIND_FEEDBACK;
                new_res.peer = sender_reg;
                new_res.fb   = cfg.score;
                map_req.addr = idx_reg[PIECE_W-1:0];
                if (can_emit)
                begin
                    if ((idx_reg < IDX_W'(total_eff)) && !dup_reg)
                    begin
                        map_req.rd_en = 1'b1;
                        state_next    = ST_A_CHK;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_A_CHK:
            begin
                map_req.addr = idx_reg[PIECE_W-1:0];
                if (emitted)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    emit          = 1'b1;
                    new_res.kind  = KIND_SEND;
                    new_res.piece = idx_reg[PIECE_W-1:0];
                    new_res.excl  = 1'b1;
                    new_res.peer  = sender_reg;
                    if (can_emit)
                    begin
                        map_req.wr_en = 1'b1;
                        state_next    = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_space)
                begin
                    fin_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (body_load.load)
        begin
            body_next = body_load.value;
        end
    end

    // one result is held back so the final one can be flagged
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (fin_push)
        begin
            pend_valid_next = 1'b0;
        end
        else if (emit && can_emit)
        begin
            pend_valid_next = 1'b1;
            pend_next       = new_res;
        end
    end

    assign push.valid = fin_push || (emit && can_emit && pend_valid_reg);
    assign push.last  = fin_push;
    assign push.res   = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            dup_reg        <= 1'b0;
            sender_reg     <= '0;
            body_reg       <= 1'b0;
            pub_reg        <= 1'b0;
            batch_go_reg   <= 1'b0;
            scan_reg       <= '0;
            left_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            dup_reg        <= dup_next;
            sender_reg     <= sender_next;
            body_reg       <= body_next;
            pub_reg        <= pub_next;
            batch_go_reg   <= batch_go_next;
            scan_reg       <= scan_next;
            left_reg       <= left_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

endmodule

[hdl/fpes_out_reg.sv]
`timescale 1ns / 1ps

module fpes_out_reg
    import fpes_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    out_space,
    input  logic    ready,
    output logic    valid,
    output logic    last,
    output result_t res
);

    logic    valid_reg;
    logic    last_reg;
    result_t res_reg;

    assign out_space = !valid_reg || ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            last_reg <= push.last;
            res_reg  <= push.res;
        end
    end

    assign valid = valid_reg;
    assign last  = last_reg;
    assign res   = res_reg;

endmodule

[hdl/fec_piece_emission_scheduler_top.sv]
// output: a result is held until the next one is made or the item ends, so the final one
// can be flagged
// throughput: one item at a time; the next transfer waits until the item's last result is
// handed to the output register; a batch scan examines each piece id by a bitmap row read,
// then a check and write back
// reset: asynchronous, active low; bitmap rows are invalidated at once, no clearing pass
`timescale 1ns / 1ps

module fec_piece_emission_scheduler_top
    import fpes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // piece_index, is_duplicate, sender_peer, zero pad
    input  logic [1:0]            s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_piece, has_exclusion, excluded_peer,
                                             // feedback_value, zero pad
    output logic [1:0]            m_tuser,   // kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DATA_USED = PIECE_W + 1 + PEER_W + SCORE_W;

    cfg_t       cfg;
    body_load_t body_load;
    map_req_t   map_req;
    logic       emitted;
    logic       out_space;
    push_t      push;
    result_t    res;

    assign cfg_ready = 1'b1;

    fpes_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .body_load (body_load)
    );

    fpes_map_ram u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .emitted (emitted)
    );

    fpes_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .body_load    (body_load),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .mode         (mode_t'(s_tuser)),
        .piece_index  (s_tdata[IDX_W-1:0]),
        .is_duplicate (s_tdata[IDX_W]),
        .sender_peer  (s_tdata[IDX_W+1 +: PEER_W]),
        .map_req      (map_req),
        .emitted      (emitted),
        .out_space    (out_space),
        .push         (push)
    );

    fpes_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_space (out_space),
        .ready     (m_tready),
        .valid     (m_tvalid),
        .last      (m_tlast),
        .res       (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {{(OUT_DATA_W - DATA_USED){1'b0}}, res.fb, res.peer, res.excl, res.piece};

endmodule

[hdl/fpes_checker.sv]
`timescale 1ns / 1ps

module fpes_checker
    import fpes_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser,
    input logic                  m_tlast
);

    localparam int EXCL_BIT = PIECE_W;
    localparam int FB_LO    = PIECE_W + 1 + PEER_W;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output changed while stalled");

    a_arm_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ARM) |-> m_tlast && (m_tdata == '0))
        else $error("arm timer result not final or not empty");

    a_deliver_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DELIVER) |-> (m_tdata == '0))
        else $error("deliver result carries data");

    a_feedback_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_FEEDBACK)
        |-> !m_tdata[EXCL_BIT] && (m_tdata[PIECE_W-1:0] == '0))
        else $error("feedback result carries a piece");

    a_send_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_SEND) |-> (m_tdata[FB_LO +: SCORE_W] == '0))
        else $error("send result carries a score");

endmodule

bind fec_piece_emission_scheduler_top fpes_checker u_fpes_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[tb/emission_checker.sv]
`timescale 1ns / 1ps

module emission_checker
    import fpes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    outstanding,
    output int                    fails
);

    typedef struct packed {
        kind_t              kind;
        logic [PIECE_W-1:0] piece;
        logic               excl;
        logic [PEER_W-1:0]  peer;
        logic [SCORE_W-1:0] fb;
        logic               last;
    } emission_t;

    emission_t emissions_due[$];

    logic [TOTAL_W-1:0]    total_cfg;
    logic [BATCH_W-1:0]    batch_cfg;
    logic                  relay_cfg;
    logic [SCORE_W-1:0]    score_cfg;
    logic [MAX_PIECES-1:0] sent_map;
    int unsigned           scan_at;
    logic                  have_body;
    logic                  is_origin;

    function automatic int unsigned pieces_live();
        return (total_cfg > MAX_PIECES) ? MAX_PIECES : int'(total_cfg);
    endfunction

    function automatic void queue_emission(kind_t kind, logic [PIECE_W-1:0] piece,
                                           logic excl, logic [PEER_W-1:0] peer,
                                           logic [SCORE_W-1:0] fb);
        emission_t e;
        e.kind  = kind;
        e.piece = piece;
        e.excl  = excl;
        e.peer  = peer;
        e.fb    = fb;
        e.last  = 1'b0;
        emissions_due = {emissions_due, e};
    endfunction

    function automatic void plan_batch();
        int unsigned total;
        int unsigned left;
        int unsigned id;
        total = pieces_live();
        if (!have_body || (!is_origin && !relay_cfg))
            return;
        left = (batch_cfg == 0) ? 1 : int'(batch_cfg);
        if (left > MAX_BATCH)
            left = MAX_BATCH;
        while (scan_at < total && left > 0)
        begin
            id = scan_at;
            scan_at++;
            if (!sent_map[id])
            begin
                sent_map[id] = 1'b1;
                queue_emission(KIND_SEND, PIECE_W'(id), 1'b0, '0, '0);
                left--;
            end
        end
        if (scan_at < total)
            queue_emission(KIND_ARM, '0, 1'b0, '0, '0);
    endfunction

    function automatic void forecast_event(mode_t mode, logic [IDX_W-1:0] idx, logic dup,
                                           logic [PEER_W-1:0] peer);
        int unsigned made;
        emission_t   tail;
        made = emissions_due.size();
        case (mode)
            MODE_PUBLISH:
            begin
                if (!have_body)
                begin
                    is_origin = 1'b1;
                    have_body = 1'b1;
                    queue_emission(KIND_DELIVER, '0, 1'b0, '0, '0);
                    plan_batch();
                end
            end
            MODE_BODY_READY:
            begin
                if (!have_body)
                begin
                    have_body = 1'b1;
                    queue_emission(KIND_DELIVER, '0, 1'b0, '0, '0);
                    if (relay_cfg)
                        plan_batch();
                end
            end
            MODE_TICK:
            begin
                plan_batch();
            end
            default:
            begin
                queue_emission(KIND_FEEDBACK, '0, 1'b0, peer, score_cfg);
                if (idx < pieces_live() && !dup && !sent_map[idx[PIECE_W-1:0]])
                begin
                    sent_map[idx[PIECE_W-1:0]] = 1'b1;
                    queue_emission(KIND_SEND, idx[PIECE_W-1:0], 1'b1, peer, '0);
                end
            end
        endcase
        if (emissions_due.size() > made)
        begin
            tail = emissions_due[emissions_due.size() - 1];
            tail.last = 1'b1;
            emissions_due[emissions_due.size() - 1] = tail;
        end
    endfunction

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        emission_t want;
        if (!rst_n)
        begin
            emissions_due.delete();
            total_cfg   = TOTAL_RESET;
            batch_cfg   = BATCH_RESET;
            relay_cfg   = 1'b0;
            score_cfg   = SCORE_RESET;
            sent_map    = '0;
            scan_at     = 0;
            have_body   = 1'b0;
            is_origin   = 1'b0;
            fails       = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (emissions_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result, expected none actual kind %0d data %h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = emissions_due.pop_front();
                    compare_field("kind", want.kind, m_tuser);
                    compare_field("out_piece", want.piece, m_tdata[PIECE_W-1:0]);
                    compare_field("has_exclusion", want.excl, m_tdata[PIECE_W]);
                    compare_field("excluded_peer", want.peer,
                                  m_tdata[PIECE_W+PEER_W:PIECE_W+1]);
                    compare_field("feedback_value", want.fb,
                                  m_tdata[PIECE_W+PEER_W+SCORE_W:PIECE_W+PEER_W+1]);
                    compare_field("last", want.last, m_tlast);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PIECE_TOTAL: total_cfg = cfg_data[TOTAL_W-1:0];
                    REG_BATCH_SIZE:  batch_cfg = cfg_data[BATCH_W-1:0];
                    REG_RELAY:       relay_cfg = cfg_data[0];
                    REG_START_BODY:  have_body = cfg_data[0];
                    REG_SCORE:       score_cfg = cfg_data[SCORE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                forecast_event(mode_t'(s_tuser), s_tdata[IDX_W-1:0], s_tdata[IDX_W],
                               s_tdata[IDX_W+PEER_W:IDX_W+1]);
            outstanding <= emissions_due.size();
        end
    end

endmodule

[tb/fec_piece_emission_scheduler_top_tb.sv]
`timescale 1ns / 1ps

module fec_piece_emission_scheduler_top_tb;
    import fpes_pkg::*;

    localparam int SCAN_SLACK = 2200;
    localparam int LIMIT      = 1500000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          outstanding;
    int          fails;
    int          cycles     = 0;
    logic        tx_idles   = 1'b1;
    logic        rx_stalls  = 1'b1;
    int unsigned rx_hold    = 0;
    int unsigned rx_pause;

    fec_piece_emission_scheduler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    emission_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fails       (fails)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("fec_piece_emission_scheduler_top_tb: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end
        else if (rx_hold != 0)
        begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end
        else if (m_tvalid && m_tready)
        begin
            rx_pause = rx_stalls ? $urandom_range(0, 14) : 0;
            m_tready <= (rx_pause == 0);
            rx_hold  <= rx_pause;
        end
        else
        begin
            m_tready <= rx_stalls ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    task automatic send_event(input mode_t mode, input logic [IDX_W-1:0] idx, input logic dup,
                              input logic [PEER_W-1:0] peer);
        int unsigned gap;
        gap = tx_idles ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, peer, dup, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic random_event(input int unsigned span);
        int unsigned      pick;
        mode_t            mode;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            mode = MODE_PUBLISH;
        else if (pick < 4)
            mode = MODE_BODY_READY;
        else if (pick < 12)
            mode = MODE_TICK;
        else
            mode = MODE_PIECE;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            idx = IDX_W'($urandom_range(0, MAX_PIECES - 1));
        else if (pick < 9)
            idx = IDX_W'(span) + IDX_W'($urandom_range(0, 3)) - IDX_W'(2);
        else
            idx = IDX_W'($urandom);
        send_event(mode, idx, $urandom_range(0, 3) == 0, PEER_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // wait for all results, then for a scan that may end without any result
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SCAN_SLACK) @(posedge clk);
    endtask

    task automatic set_phase(input logic [CFG_DATA_W-1:0] total,
                             input logic [CFG_DATA_W-1:0] batch,
                             input logic [CFG_DATA_W-1:0] relay,
                             input logic [CFG_DATA_W-1:0] start,
                             input logic [CFG_DATA_W-1:0] score);
        settle();
        tx_idles  <= ($urandom_range(0, 3) != 0);
        rx_stalls <= ($urandom_range(0, 3) != 0);
        write_reg(REG_SCORE + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
        write_reg(REG_PIECE_TOTAL, total);
        write_reg(REG_BATCH_SIZE, batch);
        write_reg(REG_RELAY, relay);
        write_reg(REG_START_BODY, start);
        write_reg(REG_SCORE, score);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] total;
        logic [CFG_DATA_W-1:0] batch;
        int unsigned           pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no body, not publisher, no relay
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_PIECE, 16'hFFFF, 1'b0, 16'hFFFF);
        send_event(MODE_PIECE, 16'd5, 1'b1, 16'h0000);
        send_event(MODE_PIECE, 16'd5, 1'b0, 16'hA5A5);
        send_event(MODE_PIECE, 16'd5, 1'b0, 16'h5A5A);
        send_event(MODE_BODY_READY, '0, 1'b0, '0);
        send_event(MODE_BODY_READY, '0, 1'b0, '0);
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_PUBLISH, '0, 1'b0, '0);

        // relaying non-publisher, batch size zero, most negative score
        set_phase(11'd8, 11'd0, 11'd1, 11'd0, 11'h080);
        send_event(MODE_BODY_READY, '0, 1'b0, '0);
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_PIECE, 16'd1023, 1'b0, 16'h1234);
        send_event(MODE_PIECE, 16'd7, 1'b0, 16'h8001);
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_TICK, '0, 1'b0, '0);

        // oversized total and batch, publisher, full batches
        set_phase(11'd2047, 11'd63, 11'd0, 11'd0, 11'h07F);
        send_event(MODE_PUBLISH, '0, 1'b0, '0);
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_PIECE, 16'd1023, 1'b0, 16'hFFFF);

        // zero total with body present from the start flag
        set_phase(11'd0, 11'd32, 11'h7FF, 11'h7FF, 11'h700);
        send_event(MODE_PUBLISH, '0, 1'b0, '0);
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_PIECE, 16'd0, 1'b0, 16'h0F0F);

        set_phase(11'd1, 11'd1, 11'd0, 11'd0, 11'd1);
        send_event(MODE_TICK, '0, 1'b0, '0);
        send_event(MODE_BODY_READY, '0, 1'b0, '0);

        for (int p = 0; p < 5; p++)
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                total = (p % 2 == 0) ? CFG_DATA_W'(0)
                                     : CFG_DATA_W'($urandom_range(MAX_PIECES + 1, 2047));
            else
                total = CFG_DATA_W'($urandom_range(64, MAX_PIECES));
            batch = ($urandom_range(0, 3) != 0) ? CFG_DATA_W'($urandom_range(0, 8))
                                                : CFG_DATA_W'($urandom_range(0, 63));
            set_phase(total, batch, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom));
            repeat (15) random_event(total);
        end

        settle();
        if (fails == 0 && outstanding == 0)
        begin
            $display("fec_piece_emission_scheduler_top_tb: done, clean");
        end
        else
        begin
            $display("fec_piece_emission_scheduler_top_tb: done, errors");
        end
        $finish;
    end

endmodule
